### rtl/core/pipr_pkg.sv
// Shared types and constants for the point-in-polygon ray vote core.
`default_nettype none
package pipr_pkg;

    localparam int COORD_BITS = 16;
    localparam int DW         = COORD_BITS + 1;
    localparam int PW         = 2 * DW;
    localparam int CFG_IW     = 3;

    typedef logic signed [COORD_BITS-1:0] t_crd;
    typedef logic signed [DW-1:0]         t_dif;
    typedef logic signed [PW-1:0]         t_prd;
    typedef logic [CFG_IW-1:0]            t_reg_idx;

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_QUERY  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind kind;
        t_crd  coord_x;
        t_crd  coord_y;
    } t_in_item;

    typedef struct packed {
        logic       inside_res;
        logic [1:0] odd_rays;
    } t_out_item;

    typedef struct packed {
        t_crd y;
        t_crd x;
    } t_vtx;

    typedef struct packed {
        t_crd x0;
        t_crd y0;
        t_crd x1;
        t_crd y1;
    } t_edge;

    typedef struct packed {
        logic clr;
        logic vld;
    } t_lane_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_LAST,
        ST_TAIL,
        ST_DRAIN,
        ST_FIN
    } t_state;

    localparam t_reg_idx REG_P1_X = 3'd0;
    localparam t_reg_idx REG_P1_Y = 3'd1;
    localparam t_reg_idx REG_P2_X = 3'd2;
    localparam t_reg_idx REG_P2_Y = 3'd3;
    localparam t_reg_idx REG_P3_X = 3'd4;
    localparam t_reg_idx REG_P3_Y = 3'd5;

    localparam t_crd P1_X_RST = t_crd'(-17605);
    localparam t_crd P1_Y_RST = t_crd'(-18);
    localparam t_crd P2_X_RST = t_crd'(17605);
    localparam t_crd P2_Y_RST = t_crd'(-21);
    localparam t_crd P3_X_RST = t_crd'(17605);
    localparam t_crd P3_Y_RST = t_crd'(17557);

endpackage
`default_nettype wire

### rtl/core/point_in_polygon_ray_vote_core.sv
// Top level of the point-in-polygon ray vote core: vertex store, walk control, vote.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------------
//  in      | to core   | i_in_valid / o_in_stall    | i_in_item  (kind, x, y)
//  out     | from core | o_out_valid / i_out_stall  | o_out_item (inside, odd rays)
//  cfg     | to core   | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// A query walks the vertex RAM read port at one vertex per cycle; a query on an
// empty polygon skips the walk.
// Synchronous reset empties the polygon and loads the default pivots; the RAM is
// not cleared. A finished result waits in the output register; the next item is
// accepted meanwhile, and a later query only holds in its final cycle for the slot.
`default_nettype none
module point_in_polygon_ray_vote_core #(
    parameter int MAX_VERTICES = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  pipr_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output pipr_pkg::t_out_item  o_out_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  pipr_pkg::t_reg_idx   i_cfg_index,
    input  pipr_pkg::t_crd       i_cfg_data
);
    import pipr_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    t_state r_state, n_state;

    logic [CW-1:0] r_count;
    logic [CW-1:0] r_rd_idx;
    logic          r_dat_vld, r_dat_first;
    t_crd          r_px, r_py;
    t_crd          r_piv_x [3];
    t_crd          r_piv_y [3];
    t_vtx          r_first, r_prev, rdata;
    t_edge         r_edge;
    logic          r_edge_vld;
    logic          r_out_vld;
    t_out_item     r_out_item;

    logic          in_acc, cfg_we, app_we, qry_acc;
    logic          rd_en, out_ld, last_idx, edge_ld;
    logic [2:0]    busy, odd;
    logic [1:0]    odd_cnt;
    t_lane_ctl     lane_ctl;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign qry_acc     = in_acc && (i_in_item.kind == KIND_QUERY);
    assign app_we      = in_acc && (i_in_item.kind == KIND_APPEND)
                      && (r_count < CW'(MAX_VERTICES));
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign last_idx    = (r_rd_idx + CW'(1)) == r_count;
    assign edge_ld     = (r_dat_vld && !r_dat_first) || (r_state == ST_TAIL);

    pipr_ram #(
        .WIDTH ($bits(t_vtx)),
        .DEPTH (MAX_VERTICES)
    ) u_vtx_ram (
        .i_clk   (i_clk),
        .i_we    (app_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({i_in_item.coord_y, i_in_item.coord_x}),
        .i_re    (rd_en),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        rd_en   = 1'b0;
        out_ld  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (qry_acc) begin
                    n_state = (r_count == '0) ? ST_DRAIN : ST_WALK;
                end
            end
            ST_WALK: begin
                rd_en = 1'b1;
                if (last_idx) begin
                    n_state = ST_LAST;
                end
            end
            ST_LAST:  n_state = ST_TAIL;
            ST_TAIL:  n_state = ST_DRAIN;
            ST_DRAIN: begin
                if (!r_edge_vld && (busy == '0)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_out_vld || !i_out_stall) begin
                    out_ld  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_dat_vld   <= 1'b0;
            r_dat_first <= 1'b0;
            r_edge_vld  <= 1'b0;
            r_out_vld   <= 1'b0;
            r_piv_x[0]  <= P1_X_RST;
            r_piv_y[0]  <= P1_Y_RST;
            r_piv_x[1]  <= P2_X_RST;
            r_piv_y[1]  <= P2_Y_RST;
            r_piv_x[2]  <= P3_X_RST;
            r_piv_y[2]  <= P3_Y_RST;
        end else begin
            if (cfg_we) begin
                unique case (i_cfg_index)
                    REG_P1_X: r_piv_x[0] <= i_cfg_data;
                    REG_P1_Y: r_piv_y[0] <= i_cfg_data;
                    REG_P2_X: r_piv_x[1] <= i_cfg_data;
                    REG_P2_Y: r_piv_y[1] <= i_cfg_data;
                    REG_P3_X: r_piv_x[2] <= i_cfg_data;
                    REG_P3_Y: r_piv_y[2] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_acc && (i_in_item.kind == KIND_CLEAR)) begin
                r_count <= '0;
            end else if (app_we) begin
                r_count <= r_count + CW'(1);
            end
            if (r_state == ST_IDLE) begin
                r_rd_idx <= '0;
            end else if (rd_en) begin
                r_rd_idx <= r_rd_idx + CW'(1);
            end
            r_dat_vld   <= rd_en;
            r_dat_first <= rd_en && (r_rd_idx == '0);
            r_edge_vld  <= edge_ld;
            if (out_ld) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (qry_acc) begin
            r_px <= i_in_item.coord_x;
            r_py <= i_in_item.coord_y;
        end
        if (r_dat_vld) begin
            r_prev <= rdata;
            if (r_dat_first) begin
                r_first <= rdata;
            end
        end
        if (r_state == ST_TAIL) begin
            r_edge <= '{x0: r_prev.x, y0: r_prev.y, x1: r_first.x, y1: r_first.y};
        end else begin
            r_edge <= '{x0: r_prev.x, y0: r_prev.y, x1: rdata.x, y1: rdata.y};
        end
        if (out_ld) begin
            r_out_item.inside_res <= odd_cnt[1];
            r_out_item.odd_rays   <= odd_cnt;
        end
    end

    assign lane_ctl = '{clr: qry_acc, vld: r_edge_vld};

    for (genvar g = 0; g < 3; g++) begin : g_ray
        pipr_cross u_cross (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (lane_ctl),
            .i_edge  (r_edge),
            .i_px    (r_px),
            .i_py    (r_py),
            .i_qx    (r_piv_x[g]),
            .i_qy    (r_piv_y[g]),
            .o_busy  (busy[g]),
            .o_odd   (odd[g])
        );
    end

    assign odd_cnt     = {1'b0, odd[0]} + {1'b0, odd[1]} + {1'b0, odd[2]};
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;
endmodule
`default_nettype wire

### rtl/core/pipr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module pipr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

### rtl/core/pipr_cross.sv
// Pipelined edge/ray proper-crossing test with a running crossing parity.
`default_nettype none
module pipr_cross (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pipr_pkg::t_lane_ctl i_ctl,
    input  pipr_pkg::t_edge    i_edge,
    input  pipr_pkg::t_crd     i_px,
    input  pipr_pkg::t_crd     i_py,
    input  pipr_pkg::t_crd     i_qx,
    input  pipr_pkg::t_crd     i_qy,
    output logic               o_busy,
    output logic               o_odd
);
    import pipr_pkg::*;

    t_crd ex_lo, ex_hi, ey_lo, ey_hi, sx_lo, sx_hi, sy_lo, sy_hi;
    logic box_ok;

    logic r_s1_vld, r_s1_box;
    t_dif r_dex, r_dey, r_a1x, r_a1y, r_a2x, r_a2y;
    t_dif r_sdx, r_sdy, r_b1x, r_b1y, r_b2x, r_b2y;

    logic r_s2_vld, r_s2_box;
    t_prd r_m1a, r_m1b, r_m2a, r_m2b, r_m3a, r_m3b, r_m4a, r_m4b;

    logic pos1, neg1, pos2, neg2, pos3, neg3, pos4, neg4, hit;
    logic r_par;

    always_comb begin
        ex_lo  = (i_edge.x0 < i_edge.x1) ? i_edge.x0 : i_edge.x1;
        ex_hi  = (i_edge.x0 < i_edge.x1) ? i_edge.x1 : i_edge.x0;
        ey_lo  = (i_edge.y0 < i_edge.y1) ? i_edge.y0 : i_edge.y1;
        ey_hi  = (i_edge.y0 < i_edge.y1) ? i_edge.y1 : i_edge.y0;
        sx_lo  = (i_px < i_qx) ? i_px : i_qx;
        sx_hi  = (i_px < i_qx) ? i_qx : i_px;
        sy_lo  = (i_py < i_qy) ? i_py : i_qy;
        sy_hi  = (i_py < i_qy) ? i_qy : i_py;
        box_ok = !((ex_lo > sx_hi) || (sx_lo > ex_hi) || (ey_lo > sy_hi) || (sy_lo > ey_hi));
    end

    always_ff @(posedge i_clk) begin
        r_dex <= t_dif'(i_edge.x1) - t_dif'(i_edge.x0);
        r_dey <= t_dif'(i_edge.y1) - t_dif'(i_edge.y0);
        r_a1x <= t_dif'(i_px) - t_dif'(i_edge.x0);
        r_a1y <= t_dif'(i_py) - t_dif'(i_edge.y0);
        r_a2x <= t_dif'(i_qx) - t_dif'(i_edge.x0);
        r_a2y <= t_dif'(i_qy) - t_dif'(i_edge.y0);
        r_sdx <= t_dif'(i_qx) - t_dif'(i_px);
        r_sdy <= t_dif'(i_qy) - t_dif'(i_py);
        r_b1x <= t_dif'(i_edge.x0) - t_dif'(i_px);
        r_b1y <= t_dif'(i_edge.y0) - t_dif'(i_py);
        r_b2x <= t_dif'(i_edge.x1) - t_dif'(i_px);
        r_b2y <= t_dif'(i_edge.y1) - t_dif'(i_py);
        r_s1_box <= box_ok;

        r_m1a <= r_a1x * r_dey;
        r_m1b <= r_dex * r_a1y;
        r_m2a <= r_a2x * r_dey;
        r_m2b <= r_dex * r_a2y;
        r_m3a <= r_b1x * r_sdy;
        r_m3b <= r_sdx * r_b1y;
        r_m4a <= r_b2x * r_sdy;
        r_m4b <= r_sdx * r_b2y;
        r_s2_box <= r_s1_box;
    end

    // sign of each cross product from comparing its two terms
    always_comb begin
        pos1 = r_m1a > r_m1b;
        neg1 = r_m1a < r_m1b;
        pos2 = r_m2a > r_m2b;
        neg2 = r_m2a < r_m2b;
        pos3 = r_m3a > r_m3b;
        neg3 = r_m3a < r_m3b;
        pos4 = r_m4a > r_m4b;
        neg4 = r_m4a < r_m4b;
        hit  = r_s2_box && ((pos1 && neg2) || (neg1 && pos2))
                        && ((pos3 && neg4) || (neg3 && pos4));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_par    <= 1'b0;
        end else begin
            r_s1_vld <= i_ctl.vld;
            r_s2_vld <= r_s1_vld;
            if (i_ctl.clr) begin
                r_par <= 1'b0;
            end else if (r_s2_vld && hit) begin
                r_par <= !r_par;
            end
        end
    end

    assign o_busy = r_s1_vld || r_s2_vld;
    assign o_odd  = r_par;
endmodule
`default_nettype wire

### rtl/core/pipr_chk.sv
// Port-level assertions for the point-in-polygon ray vote core, with bind.
`default_nettype none
module pipr_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input pipr_pkg::t_in_item   i_in_item,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input pipr_pkg::t_out_item  o_out_item
);
    import pipr_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_item))
        else $error("stalled result changed");

    a_vote: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.inside_res == o_out_item.odd_rays[1]))
        else $error("inside flag disagrees with odd ray count");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_item.kind == KIND_QUERY) |=> o_in_stall)
        else $error("item taken while query walk runs");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result present after reset");
endmodule

bind point_in_polygon_ray_vote_core pipr_chk u_pipr_chk (.*);
`default_nettype wire

### sim/point_in_polygon_ray_vote_core_tb.sv
// Self-checking testbench for the point-in-polygon ray vote core: polygon loads, queries, pivots.
module point_in_polygon_ray_vote_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pipr_pkg::*;

    localparam int       MAX_VERTICES  = 256;
    localparam int       SETTLE_CYCLES = MAX_VERTICES + 16;
    localparam longint   CRD_MAX       = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    localparam longint   CRD_MIN       = -(longint'(1) <<< (COORD_BITS - 1));
    localparam t_kind    KIND_UNUSED   = t_kind'(2'd3);
    localparam t_reg_idx REG_SPARE_LO  = 3'd6;
    localparam t_reg_idx REG_SPARE_HI  = 3'd7;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      in_valid    = 1'b0;
    logic      in_stall;
    t_in_item  in_item     = '0;
    logic      out_valid;
    logic      out_stall   = 1'b0;
    t_out_item out_item;
    logic      cfg_valid   = 1'b0;
    logic      cfg_ready;
    t_reg_idx  cfg_index   = '0;
    t_crd      cfg_data    = '0;

    t_in_item  item_q[$];
    t_out_item vote_q[$];
    t_out_item vote_due;

    t_crd      poly_x[MAX_VERTICES];
    t_crd      poly_y[MAX_VERTICES];
    int        poly_count = 0;
    t_crd      pivot_reg[0:5] = '{P1_X_RST, P1_Y_RST, P2_X_RST, P2_Y_RST, P3_X_RST, P3_Y_RST};

    int        mismatches  = 0;
    int        stim_count  = 0;
    int        burst_left  = 0;
    int        gap_left    = 0;
    int        gap_pick;
    int        stall_mode  = 0;
    int        stall_timer = 0;

    point_in_polygon_ray_vote_core #(
        .MAX_VERTICES(MAX_VERTICES)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // ---------------------------------------------------------------- prediction

    function automatic longint wedge(input longint ux, input longint uy,
                                     input longint vx, input longint vy);
        return ux * vy - vx * uy;
    endfunction

    function automatic bit opposite(input longint a, input longint b);
        return (a > 0 && b < 0) || (a < 0 && b > 0);
    endfunction

    function automatic bit ray_crosses(input longint ex0, input longint ey0,
                                       input longint ex1, input longint ey1,
                                       input longint sx0, input longint sy0,
                                       input longint sx1, input longint sy1);
        longint exl = (ex0 < ex1) ? ex0 : ex1;
        longint exh = (ex0 < ex1) ? ex1 : ex0;
        longint eyl = (ey0 < ey1) ? ey0 : ey1;
        longint eyh = (ey0 < ey1) ? ey1 : ey0;
        longint sxl = (sx0 < sx1) ? sx0 : sx1;
        longint sxh = (sx0 < sx1) ? sx1 : sx0;
        longint syl = (sy0 < sy1) ? sy0 : sy1;
        longint syh = (sy0 < sy1) ? sy1 : sy0;
        if (exl > sxh || sxl > exh || eyl > syh || syl > eyh)
            return 1'b0;
        if (!opposite(wedge(sx0 - ex0, sy0 - ey0, ex1 - ex0, ey1 - ey0),
                      wedge(sx1 - ex0, sy1 - ey0, ex1 - ex0, ey1 - ey0)))
            return 1'b0;
        return opposite(wedge(ex0 - sx0, ey0 - sy0, sx1 - sx0, sy1 - sy0),
                        wedge(ex1 - sx0, ey1 - sy0, sx1 - sx0, sy1 - sy0));
    endfunction

    function automatic t_out_item ray_vote(input t_crd qx, input t_crd qy);
        t_out_item   v;
        int unsigned odd;
        int          hits;
        int          j;
        odd = 0;
        for (int r = 0; r < 3; r++) begin
            hits = 0;
            for (int i = 0; i < poly_count; i++) begin
                j = (i + 1 < poly_count) ? i + 1 : 0;
                if (ray_crosses(poly_x[i], poly_y[i], poly_x[j], poly_y[j],
                                qx, qy, pivot_reg[2*r], pivot_reg[2*r+1]))
                    hits++;
            end
            odd += hits & 1;
        end
        v.inside_res = (odd >= 2);
        v.odd_rays   = odd[1:0];
        return v;
    endfunction

    function automatic void track_item(input t_in_item it);
        case (it.kind)
            KIND_CLEAR: begin
                poly_count = 0;
            end
            KIND_APPEND: begin
                if (poly_count < MAX_VERTICES) begin
                    poly_x[poly_count] = it.coord_x;
                    poly_y[poly_count] = it.coord_y;
                    poly_count++;
                end
            end
            KIND_QUERY: begin
                vote_q.insert(vote_q.size(), ray_vote(it.coord_x, it.coord_y));
            end
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------- driver

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall)
                track_item(in_item);
            if (!in_valid || !in_stall) begin
                if (gap_left > 0) begin
                    in_valid <= 1'b0;
                    gap_left--;
                end else if (item_q.size() != 0) begin
                    in_valid <= 1'b1;
                    in_item  <= item_q.pop_front();
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_pick   = $urandom_range(0, 9);
                        gap_left   = (gap_pick < 3) ? 0 :
                                     (gap_pick < 9) ? $urandom_range(1, 12) :
                                                      $urandom_range(20, 300);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 50)
            $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (vote_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result inside=%0b odd=%0d",
                                              out_item.inside_res, out_item.odd_rays));
                end else begin
                    vote_due = vote_q.pop_front();
                    if (out_item.inside_res !== vote_due.inside_res)
                        report_mismatch($sformatf("inside_res got %0b exp %0b",
                                                  out_item.inside_res, vote_due.inside_res));
                    if (out_item.odd_rays !== vote_due.odd_rays)
                        report_mismatch($sformatf("odd_rays got %0d exp %0d",
                                                  out_item.odd_rays, vote_due.odd_rays));
                end
            end
            if (stall_timer == 0) begin
                stall_timer = $urandom_range(50, 400);
                stall_mode  = $urandom_range(0, 2);
            end else begin
                stall_timer--;
            end
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= $urandom_range(0, 1);
                default: out_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // ---------------------------------------------------------------- stimulus

    function automatic t_crd sat(input longint v);
        if (v > CRD_MAX)
            return t_crd'(CRD_MAX);
        if (v < CRD_MIN)
            return t_crd'(CRD_MIN);
        return t_crd'(v);
    endfunction

    function automatic int srand_range(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic t_crd rand_full();
        int unsigned pick = $urandom_range(0, 7);
        case (pick)
            0:       return t_crd'(CRD_MIN);
            1:       return t_crd'(CRD_MAX);
            default: return t_crd'($urandom());
        endcase
    endfunction

    function automatic longint offset(input int spread, input bit grid);
        if (grid)
            return longint'(spread / 4) * srand_range(-4, 4);
        return srand_range(-spread, spread);
    endfunction

    task automatic push_item(input t_kind k, input longint x, input longint y);
        item_q.insert(item_q.size(), '{kind: k, coord_x: sat(x), coord_y: sat(y)});
        if (k != KIND_UNUSED)
            stim_count++;
    endtask

    task automatic write_reg(input t_reg_idx idx, input t_crd val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx <= REG_P3_Y)
            pivot_reg[idx] = val;
    endtask

    task automatic write_pivots(input t_crd x1, input t_crd y1, input t_crd x2,
                                input t_crd y2, input t_crd x3, input t_crd y3);
        write_reg(REG_P1_X, x1);
        write_reg(REG_P1_Y, y1);
        write_reg(REG_P2_X, x2);
        write_reg(REG_P2_Y, y2);
        write_reg(REG_P3_X, x3);
        write_reg(REG_P3_Y, y3);
        write_reg(REG_SPARE_LO, rand_full());
        write_reg(REG_SPARE_HI, rand_full());
    endtask

    task automatic wait_idle();
        do @(posedge i_clk); while (item_q.size() != 0 || in_valid || vote_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // mostly clean polygon load + queries; the rest noise and broken sequences
    task automatic run_mixed(input int n);
        int     target;
        int     pick;
        int     nv;
        int     spread;
        bit     grid;
        longint cx;
        longint cy;
        target = stim_count + n;
        while (stim_count < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                cx     = srand_range(-20000, 20000);
                cy     = srand_range(-20000, 20000);
                spread = ($urandom_range(0, 1) != 0) ? srand_range(16, 400)
                                                     : srand_range(400, 12000);
                grid   = ($urandom_range(0, 2) == 0);
                pick   = $urandom_range(0, 19);
                nv     = (pick == 0) ? $urandom_range(0, 2) :
                         (pick < 15) ? $urandom_range(3, 8) : $urandom_range(9, 40);
                push_item(KIND_CLEAR, rand_full(), rand_full());
                for (int k = 0; k < nv; k++)
                    push_item(KIND_APPEND, cx + offset(spread, grid), cy + offset(spread, grid));
                for (int k = $urandom_range(1, 5); k > 0; k--)
                    push_item(KIND_QUERY, cx + offset(spread + spread / 2, grid),
                              cy + offset(spread + spread / 2, grid));
            end else if (pick < 90) begin
                push_item(t_kind'($urandom_range(0, 3)), rand_full(), rand_full());
            end else begin
                case ($urandom_range(0, 2))
                    0: begin
                        push_item(KIND_APPEND, rand_full(), rand_full());
                        push_item(KIND_QUERY, rand_full(), rand_full());
                    end
                    1: begin
                        push_item(KIND_CLEAR, rand_full(), rand_full());
                        push_item(KIND_CLEAR, rand_full(), rand_full());
                        push_item(KIND_QUERY, rand_full(), rand_full());
                    end
                    default: begin
                        push_item(KIND_QUERY, rand_full(), rand_full());
                        push_item(KIND_UNUSED, rand_full(), rand_full());
                        push_item(KIND_QUERY, rand_full(), rand_full());
                    end
                endcase
            end
        end
    endtask

    initial begin
        t_crd px;
        t_crd py;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty, single vertex, degenerate, square, extremes
        push_item(KIND_QUERY, 0, 0);
        push_item(KIND_UNUSED, CRD_MAX, CRD_MIN);
        push_item(KIND_APPEND, CRD_MAX, CRD_MAX);
        push_item(KIND_QUERY, CRD_MIN, CRD_MIN);
        push_item(KIND_APPEND, CRD_MIN, CRD_MIN);
        push_item(KIND_QUERY, 0, 0);
        push_item(KIND_CLEAR, 0, 0);
        push_item(KIND_APPEND, 0, 0);
        push_item(KIND_APPEND, 1600, 0);
        push_item(KIND_APPEND, 1600, 1600);
        push_item(KIND_APPEND, 0, 1600);
        push_item(KIND_QUERY, 800, 800);
        push_item(KIND_QUERY, 3200, 800);
        push_item(KIND_QUERY, 1600, 800);
        push_item(KIND_QUERY, 0, 0);
        push_item(KIND_QUERY, 800, 0);
        push_item(KIND_CLEAR, CRD_MAX, CRD_MAX);
        push_item(KIND_APPEND, CRD_MIN, CRD_MIN);
        push_item(KIND_APPEND, CRD_MAX, CRD_MIN);
        push_item(KIND_APPEND, 0, CRD_MAX);
        push_item(KIND_QUERY, 0, 0);
        push_item(KIND_QUERY, CRD_MAX, CRD_MAX);
        push_item(KIND_QUERY, CRD_MIN, CRD_MAX);
        run_mixed(250);
        wait_idle();

        write_pivots(t_crd'(CRD_MIN), t_crd'(CRD_MIN), t_crd'(CRD_MAX),
                     t_crd'(CRD_MIN), t_crd'(CRD_MAX), t_crd'(CRD_MAX));
        run_mixed(250);
        wait_idle();

        write_pivots(rand_full(), rand_full(), rand_full(),
                     rand_full(), rand_full(), rand_full());
        run_mixed(250);
        wait_idle();

        // short rays; polygon filled past capacity
        write_pivots(sat(srand_range(-2000, 2000)), sat(srand_range(-2000, 2000)),
                     sat(srand_range(-2000, 2000)), sat(srand_range(-2000, 2000)),
                     sat(srand_range(-2000, 2000)), sat(srand_range(-2000, 2000)));
        push_item(KIND_CLEAR, 0, 0);
        for (int k = 0; k < MAX_VERTICES + 8; k++)
            push_item(KIND_APPEND, srand_range(-3000, 3000), srand_range(-3000, 3000));
        for (int k = 0; k < 4; k++)
            push_item(KIND_QUERY, srand_range(-3000, 3000), srand_range(-3000, 3000));
        run_mixed(250);
        wait_idle();

        // all three rays to one point
        px = rand_full();
        py = rand_full();
        write_pivots(px, py, px, py, px, py);
        run_mixed(250);
        wait_idle();

        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
